>>> design/ial_pkg.sv
// Shared types and constants for the indexed array list engine.
// Used by ial_seq, ial_chk and the top level; depends on nothing else.
package ial_pkg;

    localparam int DEPTH = 256;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = AW + 1;
    localparam int DW    = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_CHANGE = 2'd2,
        OP_FIND   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_INDEX = 2'd1,
        ST_FULL      = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_TAIL,
        S_FINISH
    } state_t;

    typedef struct packed {
        logic [1:0]           func;
        logic [8:0]           position;
        logic signed [31:0]   value;
    } req_t;

    typedef struct packed {
        logic [1:0] status;
        logic       found;
        logic [7:0] found_position;
        logic [8:0] count;
    } rsp_t;

    typedef struct packed {
        logic          we;
        logic [AW-1:0] waddr;
        logic [DW-1:0] wdata;
        logic [AW-1:0] raddr;
    } mem_req_t;

endpackage

>>> design/ial_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module ial_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> design/ial_seq.sv
// Sequencer of the list engine: walks the store one entry a cycle through the
// RAM port, shifting entries for insert and delete and comparing for find.
// Depends on ial_pkg.
module ial_seq (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    input  ial_pkg::req_t     req,
    output logic              req_stall,
    input  logic [31:0]       rd_data,
    output ial_pkg::mem_req_t mem,
    output logic              res_valid,
    output ial_pkg::rsp_t     res,
    input  logic              res_take
);

    ial_pkg::state_t         state_reg, state_next;
    logic [ial_pkg::CW-1:0]  cnt_reg, cnt_next;
    logic [1:0]              op_reg, op_next;
    logic [8:0]              pos_reg, pos_next;
    logic [31:0]             val_reg, val_next;
    logic [ial_pkg::CW-1:0]  idx_reg, idx_next;
    logic                    pend_reg, pend_next;
    logic [ial_pkg::CW-1:0]  pidx_reg, pidx_next;
    logic [1:0]              status_reg, status_next;
    logic                    found_reg, found_next;
    logic [7:0]              fpos_reg, fpos_next;

    logic                    accept;
    logic                    req_bad;
    logic                    req_full;
    logic                    hit_now;
    logic                    walk_go;
    logic [ial_pkg::CW-1:0]  rd_idx;

    assign accept = (state_reg == ial_pkg::S_IDLE) && req_valid;

    always_comb
    begin
        req_bad  = 1'b0;
        req_full = 1'b0;
        case (ial_pkg::op_t'(req.func))
            ial_pkg::OP_INSERT:
            begin
                req_bad  = req.position > cnt_reg;
                req_full = cnt_reg == ial_pkg::CW'(ial_pkg::DEPTH);
            end
            ial_pkg::OP_DELETE, ial_pkg::OP_CHANGE:
            begin
                req_bad = req.position >= cnt_reg;
            end
            default:
            begin
                req_bad = 1'b0;
            end
        endcase
    end

    // A compare is pending for the entry read in the previous cycle.
    assign hit_now = pend_reg && (op_reg == ial_pkg::OP_FIND) && (rd_data == val_reg);

    always_comb
    begin
        case (ial_pkg::op_t'(op_reg))
            ial_pkg::OP_INSERT: walk_go = idx_reg != pos_reg;
            ial_pkg::OP_FIND:   walk_go = !hit_now && (idx_reg < cnt_reg);
            default:            walk_go = idx_reg < cnt_reg;
        endcase
    end

    // Insert walks downward and reads the entry below; the others read in place.
    assign rd_idx = (op_reg == ial_pkg::OP_INSERT) ? idx_reg - 1'b1 : idx_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ial_pkg::S_IDLE:
            begin
                if (req_valid)
                begin
                    if (req_bad || req_full)
                    begin
                        state_next = ial_pkg::S_FINISH;
                    end
                    else if (req.func == ial_pkg::OP_CHANGE)
                    begin
                        state_next = ial_pkg::S_TAIL;
                    end
                    else
                    begin
                        state_next = ial_pkg::S_WALK;
                    end
                end
            end
            ial_pkg::S_WALK:
            begin
                if (!walk_go)
                begin
                    state_next = (op_reg == ial_pkg::OP_FIND) ? ial_pkg::S_FINISH
                                                              : ial_pkg::S_TAIL;
                end
            end
            ial_pkg::S_TAIL:
            begin
                state_next = ial_pkg::S_FINISH;
            end
            ial_pkg::S_FINISH:
            begin
                if (res_take)
                begin
                    state_next = ial_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ial_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        req_stall = state_reg != ial_pkg::S_IDLE;
        res_valid = state_reg == ial_pkg::S_FINISH;
        res.status         = status_reg;
        res.found          = found_reg;
        res.found_position = fpos_reg;
        res.count          = cnt_reg;
        mem.we    = 1'b0;
        mem.waddr = pidx_reg[ial_pkg::AW-1:0];
        mem.wdata = rd_data;
        mem.raddr = rd_idx[ial_pkg::AW-1:0];
        case (state_reg)
            ial_pkg::S_WALK:
            begin
                mem.we = pend_reg && (op_reg != ial_pkg::OP_FIND);
            end
            ial_pkg::S_TAIL:
            begin
                mem.we    = (op_reg == ial_pkg::OP_INSERT) || (op_reg == ial_pkg::OP_CHANGE);
                mem.waddr = pos_reg[ial_pkg::AW-1:0];
                mem.wdata = val_reg;
            end
            default:
            begin
                mem.we = 1'b0;
            end
        endcase
    end

    // Datapath.
    always_comb
    begin
        cnt_next    = cnt_reg;
        op_next     = op_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        idx_next    = idx_reg;
        pend_next   = pend_reg;
        pidx_next   = pidx_reg;
        status_next = status_reg;
        found_next  = found_reg;
        fpos_next   = fpos_reg;
        case (state_reg)
            ial_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = req.func;
                    pos_next   = req.position;
                    val_next   = req.value;
                    pend_next  = 1'b0;
                    found_next = 1'b0;
                    fpos_next  = '0;
                    if (req_bad)
                    begin
                        status_next = 2'(ial_pkg::ST_BAD_INDEX);
                    end
                    else if (req_full)
                    begin
                        status_next = 2'(ial_pkg::ST_FULL);
                    end
                    else
                    begin
                        status_next = 2'(ial_pkg::ST_OK);
                    end
                    case (ial_pkg::op_t'(req.func))
                        ial_pkg::OP_INSERT: idx_next = cnt_reg;
                        ial_pkg::OP_DELETE: idx_next = req.position + 1'b1;
                        default:            idx_next = '0;
                    endcase
                end
            end
            ial_pkg::S_WALK:
            begin
                if (hit_now)
                begin
                    found_next = 1'b1;
                    fpos_next  = pidx_reg[7:0];
                end
                pend_next = walk_go;
                if (walk_go)
                begin
                    case (ial_pkg::op_t'(op_reg))
                        ial_pkg::OP_INSERT:
                        begin
                            pidx_next = idx_reg;
                            idx_next  = idx_reg - 1'b1;
                        end
                        ial_pkg::OP_DELETE:
                        begin
                            pidx_next = idx_reg - 1'b1;
                            idx_next  = idx_reg + 1'b1;
                        end
                        default:
                        begin
                            pidx_next = idx_reg;
                            idx_next  = idx_reg + 1'b1;
                        end
                    endcase
                end
            end
            ial_pkg::S_TAIL:
            begin
                if (op_reg == ial_pkg::OP_INSERT)
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
                else if (op_reg == ial_pkg::OP_DELETE)
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ial_pkg::S_IDLE;
            cnt_reg   <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        idx_reg    <= idx_next;
        pidx_reg   <= pidx_next;
        status_reg <= status_next;
        found_reg  <= found_next;
        fpos_reg   <= fpos_next;
    end

endmodule

>>> design/indexed_array_list_engine.sv
// Top level of the indexed array list engine: sequencer, element RAM and
// the result register. Depends on ial_pkg, ial_ram and ial_seq.
//
//   channel | payload         | handshake
//   --------+-----------------+---------------------------
//   req     | ial_pkg::req_t  | req_valid in, req_stall out
//   rsp     | ial_pkg::rsp_t  | rsp_valid out, rsp_stall in
//
// One beat is taken at a time. A rejected request goes straight to the result,
// and a change writes its entry in the tail state. Find compares the entries in
// order until a hit or the end of the list; insert and delete move entries one
// at a time through the RAM, and the tail state then updates the count.
// Reset clears the entry count; the store itself is not cleared.
// The result register lets the next request start while rsp is stalled.
module indexed_array_list_engine (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    input  ial_pkg::req_t req,
    output logic          req_stall,
    output logic          rsp_valid,
    output ial_pkg::rsp_t rsp,
    input  logic          rsp_stall
);

    ial_pkg::mem_req_t mem;
    logic [31:0]       rd_data;
    logic              res_valid;
    ial_pkg::rsp_t     res;
    logic              res_take;
    logic              rsp_valid_reg;
    ial_pkg::rsp_t     rsp_reg;

    ial_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req       (req),
        .req_stall (req_stall),
        .rd_data   (rd_data),
        .mem       (mem),
        .res_valid (res_valid),
        .res       (res),
        .res_take  (res_take)
    );

    ial_ram #(
        .WIDTH (ial_pkg::DW),
        .DEPTH (ial_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem.we),
        .waddr (mem.waddr),
        .wdata (mem.wdata),
        .raddr (mem.raddr),
        .rdata (rd_data)
    );

    // The result moves into the output register once it is empty or draining.
    assign res_take = res_valid && (!rsp_valid_reg || !rsp_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (res_take)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_take)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

>>> design/ial_chk.sv
// Port-level checks for the indexed array list engine, bound to the top level.
// Depends on ial_pkg.
module ial_chk (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input ial_pkg::req_t req,
    input logic          req_stall,
    input logic          rsp_valid,
    input ial_pkg::rsp_t rsp,
    input logic          rsp_stall
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("response beat changed while stalled");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.count <= 9'(ial_pkg::DEPTH))
        else $error("entry count beyond store depth");

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.found |-> rsp.status == 2'(ial_pkg::ST_OK))
        else $error("found flag set on a failed request");

    a_miss_pos: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.found |-> rsp.found_position == 8'd0)
        else $error("found position nonzero without a hit");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> rsp.status == 2'(ial_pkg::ST_OK)
                   || rsp.status == 2'(ial_pkg::ST_BAD_INDEX)
                   || rsp.status == 2'(ial_pkg::ST_FULL))
        else $error("undefined status code");

endmodule

bind indexed_array_list_engine ial_chk u_ial_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req       (req),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp       (rsp),
    .rsp_stall (rsp_stall)
);
